FILE: sv/moving_average_filter_unit_macros.svh
// ----------------------------------------------------------------------------
// Moving average filter assertion macros
// Concurrent assertion helpers shared by the filter RTL.
// ----------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH
`define MOVING_AVERAGE_FILTER_UNIT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define MAF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Filter assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Filter assertion failed.");

`else

`define MAF_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: sv/maf_pkg.sv
// ----------------------------------------------------------------------------
// Moving average filter package
// Sizes and types shared by the filter modules.
// ----------------------------------------------------------------------------
package maf_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int WINDOW_MAX   = 64;
	localparam int LEN_REG_W    = 7;
	localparam int LEN_RESET    = 8;

	localparam int ADDR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int LEN_W  = $clog2(WINDOW_MAX + 1);
	localparam int SUM_W  = SAMPLE_WIDTH + ADDR_W;
	localparam int ALU_W  = SUM_W + 1;
	localparam int STEP_W = $clog2(SUM_W);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [SUM_W-1:0]        sum_t;
	typedef logic signed [ALU_W-1:0]        alu_t;
	typedef logic        [LEN_W-1:0]        len_t;
	typedef logic        [ADDR_W-1:0]       addr_t;

endpackage

FILE: sv/moving_average_filter_unit.sv
// ----------------------------------------------------------------------------
// Moving average filter unit
// Sliding-window mean of signed samples with a configurable window length.
// ----------------------------------------------------------------------------
// Usage:
// A sample request is taken on the input channel when in_valid and in_ready
// are both high. The sample is written into a 64-entry ring at the write
// pointer, and the mean of ring entries 0 to L-1 is returned on the output
// channel as one average request, truncated toward zero. L is the window
// length register (0 acts as 1, values above 64 act as 64).
// The sample RAM is read once per cycle to build the window sum, and one
// shared adder then performs a 22-step restoring division. A new sample is
// accepted only in the idle state, after the previous average has been
// loaded into the output register.
// Writing cfg_wr_en loads window_length and sets the write pointer to zero.
// Reset clears the ring to zeros through per-entry valid flags, sets the
// window length to 8 and the pointer to zero; it takes effect at once.
// A stalled receiver holds the average in the output register; the next
// sample is still accepted and processed, and the unit waits at its final
// step until the output register is free.
// ----------------------------------------------------------------------------
`include "moving_average_filter_unit_macros.svh"

module moving_average_filter_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [maf_pkg::SAMPLE_WIDTH-1:0] sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [maf_pkg::SAMPLE_WIDTH-1:0] average,
	input  logic                                  cfg_wr_en,
	input  logic        [maf_pkg::LEN_REG_W-1:0]  cfg_wr_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_ABS,
		ST_DIV,
		ST_SIGN
	} state_t;

	state_t                            state_q;
	logic [maf_pkg::LEN_REG_W-1:0]     window_length_q;
	maf_pkg::addr_t                    wp_q;
	logic [maf_pkg::WINDOW_MAX-1:0]    valid_q;
	maf_pkg::len_t                     cnt_q;
	logic                              rd_pend_s1;
	logic                              entry_ok_s1;
	maf_pkg::sum_t                     acc_q;
	logic                              neg_q;
	logic [maf_pkg::SUM_W-1:0]         dq_q;
	maf_pkg::len_t                     rem_q;
	logic [maf_pkg::STEP_W-1:0]        step_q;
	logic                              out_valid_q;
	maf_pkg::sample_t                  average_q;

	maf_pkg::len_t                     len_eff;
	logic                              accept;
	logic                              issue;
	maf_pkg::addr_t                    rd_addr;
	logic [maf_pkg::SAMPLE_WIDTH-1:0]  ram_rdata;
	maf_pkg::sample_t                  rd_sample;
	logic [maf_pkg::LEN_W:0]           shifted;
	logic                              nonneg;
	maf_pkg::addr_t                    wp_inc;
	maf_pkg::addr_t                    wp_next;
	logic                              out_load;

	maf_pkg::alu_t                     alu_a;
	maf_pkg::alu_t                     alu_b;
	logic                              alu_sub;
	maf_pkg::alu_t                     alu_y;

	always_comb begin
		if (window_length_q == '0) begin
			len_eff = maf_pkg::LEN_W'(1);
		end else if (int'(window_length_q) > maf_pkg::WINDOW_MAX) begin
			len_eff = maf_pkg::LEN_W'(maf_pkg::WINDOW_MAX);
		end else begin
			len_eff = maf_pkg::LEN_W'(window_length_q);
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign issue     = (state_q == ST_SUM) && (cnt_q < len_eff);
	assign rd_addr   = cnt_q[maf_pkg::ADDR_W-1:0];
	assign rd_sample = maf_pkg::sample_t'(ram_rdata);
	assign shifted   = {rem_q, dq_q[maf_pkg::SUM_W-1]};
	assign nonneg    = !alu_y[maf_pkg::ALU_W-1];
	assign wp_inc    = wp_q + maf_pkg::ADDR_W'(1);
	assign out_load  = (state_q == ST_SIGN) && (!out_valid_q || out_ready);

	always_comb begin
		if (cfg_wr_en) begin
			wp_next = '0;
		end else if (accept) begin
			if (maf_pkg::LEN_W'(wp_q) + maf_pkg::LEN_W'(1) >= len_eff) begin
				wp_next = '0;
			end else begin
				wp_next = wp_inc;
			end
		end else begin
			wp_next = wp_q;
		end
	end

	maf_ram #(
		.WIDTH (maf_pkg::SAMPLE_WIDTH),
		.DEPTH (maf_pkg::WINDOW_MAX)
	) u_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (wp_q),
		.wdata (sample),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// One add/subtract unit serves accumulation, negation and division.
	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_SUM: begin
				alu_a = maf_pkg::ALU_W'(acc_q);
				alu_b = entry_ok_s1 ? maf_pkg::ALU_W'(rd_sample) : '0;
			end
			ST_ABS: begin
				alu_b   = maf_pkg::ALU_W'(acc_q);
				alu_sub = 1'b1;
			end
			ST_DIV: begin
				alu_a   = maf_pkg::ALU_W'(shifted);
				alu_b   = maf_pkg::ALU_W'(len_eff);
				alu_sub = 1'b1;
			end
			ST_SIGN: begin
				alu_b   = maf_pkg::ALU_W'(dq_q);
				alu_sub = neg_q;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
		alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + maf_pkg::ALU_W'(alu_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			window_length_q <= maf_pkg::LEN_REG_W'(maf_pkg::LEN_RESET);
			wp_q            <= '0;
			valid_q         <= '0;
			cnt_q           <= '0;
			rd_pend_s1      <= 1'b0;
			entry_ok_s1     <= 1'b0;
			acc_q           <= '0;
			neg_q           <= 1'b0;
			dq_q            <= '0;
			rem_q           <= '0;
			step_q          <= '0;
			out_valid_q     <= 1'b0;
			average_q       <= '0;
		end else begin
			rd_pend_s1  <= issue;
			entry_ok_s1 <= valid_q[rd_addr];
			wp_q        <= wp_next;
			if (out_load) begin
				average_q   <= alu_y[maf_pkg::SAMPLE_WIDTH-1:0];
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						valid_q[wp_q] <= 1'b1;
						cnt_q   <= '0;
						acc_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (rd_pend_s1) begin
						acc_q <= alu_y[maf_pkg::SUM_W-1:0];
					end
					if (issue) begin
						cnt_q <= cnt_q + maf_pkg::LEN_W'(1);
					end else if (!rd_pend_s1) begin
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					neg_q   <= acc_q[maf_pkg::SUM_W-1];
					dq_q    <= acc_q[maf_pkg::SUM_W-1] ? alu_y[maf_pkg::SUM_W-1:0] : acc_q;
					rem_q   <= '0;
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= nonneg ? alu_y[maf_pkg::LEN_W-1:0] : shifted[maf_pkg::LEN_W-1:0];
					dq_q   <= {dq_q[maf_pkg::SUM_W-2:0], nonneg};
					step_q <= step_q + maf_pkg::STEP_W'(1);
					if (step_q == maf_pkg::STEP_W'(maf_pkg::SUM_W - 1)) begin
						state_q <= ST_SIGN;
					end
				end
				ST_SIGN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cfg_wr_en) begin
				window_length_q <= cfg_wr_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign average   = average_q;

	`MAF_ASSERT_IMPL(a_wp_in_window, clk, arst_n, state_q == ST_IDLE,
		maf_pkg::LEN_W'(wp_q) < len_eff)
	`MAF_ASSERT_IMPL(a_cnt_bound, clk, arst_n, state_q == ST_SUM, cnt_q <= len_eff)
	`MAF_ASSERT_IMPL(a_rem_bound, clk, arst_n, state_q == ST_DIV, rem_q < len_eff)
	`MAF_ASSERT_NEXT(a_accept_sum, clk, arst_n, accept, state_q == ST_SUM)
	`MAF_ASSERT_IMPL(a_load_from_sign, clk, arst_n, $rose(out_valid_q),
		$past(state_q) == ST_SIGN)

endmodule

FILE: sv/maf_ram.sv
// ----------------------------------------------------------------------------
// Moving average filter sample RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module maf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: tb/moving_average_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Moving average filter unit testbench
// Sends signed sample requests to the filter under random handshake stalls
// and across a series of window lengths, including zero, one, the full ring
// and lengths above the ring size. A ring model computes each truncated
// mean in step with the accepted samples, and every average request that
// comes back is compared against the oldest outstanding mean.
// ----------------------------------------------------------------------------
module moving_average_filter_unit_tb;

	localparam int QUIET_LIMIT = 5000;
	localparam int TAIL_CYCLES = 100;

	typedef logic [maf_pkg::LEN_REG_W-1:0] len_reg_t;

	class window_mean_model;
		maf_pkg::sample_t ring [maf_pkg::WINDOW_MAX];
		int unsigned wr_ptr;
		len_reg_t length_reg;
		maf_pkg::sample_t pending_means [$];
		int errors;

		function new();
			foreach (ring[i]) ring[i] = '0;
			wr_ptr = 0;
			length_reg = len_reg_t'(maf_pkg::LEN_RESET);
			errors = 0;
		endfunction

		function void write_length(len_reg_t value);
			length_reg = value;
			wr_ptr = 0;
		endfunction

		function void take_sample(maf_pkg::sample_t value);
			int unsigned span;
			longint acc;
			span = (length_reg == 0) ? 1 :
				((length_reg > maf_pkg::WINDOW_MAX) ? maf_pkg::WINDOW_MAX : length_reg);
			if (wr_ptr >= maf_pkg::WINDOW_MAX) wr_ptr = 0;
			ring[wr_ptr] = value;
			wr_ptr++;
			if (wr_ptr >= span) wr_ptr = 0;
			acc = 0;
			for (int i = 0; i < span; i++) acc += longint'(ring[i]);
			pending_means.push_back(maf_pkg::sample_t'(acc / longint'(span)));
		endfunction

		function void check_mean(maf_pkg::sample_t got);
			maf_pkg::sample_t want;
			if (pending_means.size() == 0) begin
				$display("%0t: unexpected average request, expected none, actual %0d",
					$time, got);
				errors++;
			end else begin
				want = pending_means.pop_front();
				if (got !== want) begin
					$display("%0t: average mismatch, expected %0d, actual %0d",
						$time, want, got);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	maf_pkg::sample_t sample;
	logic out_valid;
	logic out_ready = 1'b0;
	maf_pkg::sample_t average;
	logic cfg_wr_en;
	len_reg_t cfg_wr_data;

	window_mean_model model = new();
	int send_idle_pct;
	int recv_idle_pct;
	int quiet_cycles = 0;

	moving_average_filter_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.average    (average),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) model.check_mean(average);
			if (in_valid && in_ready) model.take_sample(sample);
			if ((out_valid && out_ready) || (in_valid && in_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request accepted for %0d cycles", $time, QUIET_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic send_sample(input maf_pkg::sample_t value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= value;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_for_means();
		in_valid <= 1'b0;
		do @(posedge clk); while (model.pending_means.size() != 0);
	endtask

	task automatic set_window(input len_reg_t value);
		wait_for_means();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model.write_length(value);
	endtask

	function automatic maf_pkg::sample_t pick_sample(input int mode);
		if (mode == 1 && $urandom_range(7) != 0) return maf_pkg::sample_t'(32767);
		if (mode == 2 && $urandom_range(7) != 0) return maf_pkg::sample_t'(-32768);
		case ($urandom_range(7))
			0: return maf_pkg::sample_t'(32767);
			1: return maf_pkg::sample_t'(-32768);
			2: return maf_pkg::sample_t'(int'($urandom_range(0, 31)) - 16);
			default: return maf_pkg::sample_t'($urandom);
		endcase
	endfunction

	initial begin
		len_reg_t corner_lengths [8] = '{1, 64, 127, 65, 2, 63, 0, 8};
		len_reg_t span;
		int mode;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The default window starts over a cleared ring, so the first means
		// still count zeros. Then the window fills with each extreme.
		send_sample(maf_pkg::sample_t'(32767));
		send_sample(maf_pkg::sample_t'(-32768));
		send_sample(maf_pkg::sample_t'(0));
		send_sample(maf_pkg::sample_t'(-1));
		send_sample(maf_pkg::sample_t'(1));
		repeat (8) send_sample(maf_pkg::sample_t'(32767));
		repeat (8) send_sample(maf_pkg::sample_t'(-32768));
		set_window(len_reg_t'(0));
		send_sample(maf_pkg::sample_t'(-7));
		send_sample(maf_pkg::sample_t'(32767));
		send_sample(maf_pkg::sample_t'(-32768));

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 35 : ((phase == 1) ? 66 : 0);
			recv_idle_pct = (phase == 0) ? 66 : ((phase == 1) ? 35 : 0);
			for (int seg = 0; seg < 6; seg++) begin
				span = (phase * 6 + seg < 8) ? corner_lengths[phase * 6 + seg] :
					len_reg_t'($urandom_range(0, 127));
				set_window(span);
				mode = $urandom_range(0, 3);
				for (int k = 0; k < 50; k++) begin
					send_sample(pick_sample(mode));
					if ($urandom_range(39) == 0) wait_for_means();
				end
			end
		end

		wait_for_means();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (model.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
